[hw/rtl/rsfa_pkg.sv]
// ----------------------------------------------------------------------------
// rsfa_pkg
// Types and codes shared by the rotate/shift/bit/flag ALU.
// ----------------------------------------------------------------------------
package rsfa_pkg;

	localparam logic [4:0] MODE_RLC  = 5'd0;
	localparam logic [4:0] MODE_RRC  = 5'd1;
	localparam logic [4:0] MODE_RL   = 5'd2;
	localparam logic [4:0] MODE_RR   = 5'd3;
	localparam logic [4:0] MODE_SLA  = 5'd4;
	localparam logic [4:0] MODE_SRA  = 5'd5;
	localparam logic [4:0] MODE_SLL  = 5'd6;
	localparam logic [4:0] MODE_SRL  = 5'd7;
	localparam logic [4:0] MODE_BIT  = 5'd8;
	localparam logic [4:0] MODE_RES  = 5'd9;
	localparam logic [4:0] MODE_SET  = 5'd10;
	localparam logic [4:0] MODE_RLCA = 5'd11;
	localparam logic [4:0] MODE_RRCA = 5'd12;
	localparam logic [4:0] MODE_RLA  = 5'd13;
	localparam logic [4:0] MODE_RRA  = 5'd14;
	localparam logic [4:0] MODE_DAA  = 5'd15;
	localparam logic [4:0] MODE_CPL  = 5'd16;
	localparam logic [4:0] MODE_NEG  = 5'd17;
	localparam logic [4:0] MODE_SCF  = 5'd18;
	localparam logic [4:0] MODE_CCF  = 5'd19;

	// flag bit positions
	localparam int FL_S = 7;
	localparam int FL_Z = 6;
	localparam int FL_5 = 5;
	localparam int FL_H = 4;
	localparam int FL_3 = 3;
	localparam int FL_P = 2;
	localparam int FL_N = 1;
	localparam int FL_C = 0;

	localparam logic [7:0] DAA_LO_CORR = 8'h06;
	localparam logic [7:0] DAA_HI_CORR = 8'h60;
	localparam logic [7:0] NEG_P_VAL   = 8'h80;

	typedef struct packed {
		logic [4:0] mode;
		logic [7:0] operand;
		logic [7:0] flags_in;
		logic [2:0] bit_index;
	} req_t;

	typedef struct packed {
		logic [7:0] result;
		logic [7:0] flags_out;
	} rsp_t;

endpackage

[hw/rtl/rsfa_core.sv]
// ----------------------------------------------------------------------------
// rsfa_core
// Combinational datapath: result byte and new flag byte for one request.
// ----------------------------------------------------------------------------
module rsfa_core (
	input  rsfa_pkg::req_t req,
	output rsfa_pkg::rsp_t rsp
);
	import rsfa_pkg::*;

	logic [7:0] a;
	logic [7:0] f;
	logic [7:0] r;
	logic [7:0] nf;
	logic       co;
	logic       cin;
	logic [7:0] corr;
	logic       lo_gt9;
	logic       daa_c;
	logic       daa_h;
	logic [7:0] bmask;

	assign a     = req.operand;
	assign f     = req.flags_in;
	assign cin   = f[FL_C];
	assign bmask = 8'd1 << req.bit_index;

	always_comb begin
		r      = a;
		nf     = f;
		co     = 1'b0;
		lo_gt9 = (a[3:0] > 4'd9);
		corr   = 8'h00;
		daa_c  = cin;
		daa_h  = 1'b0;
		case (req.mode)
			MODE_RLC, MODE_RLCA: begin r = {a[6:0], a[7]}; co = a[7]; end
			MODE_RRC, MODE_RRCA: begin r = {a[0], a[7:1]}; co = a[0]; end
			MODE_RL,  MODE_RLA:  begin r = {a[6:0], cin};  co = a[7]; end
			MODE_RR,  MODE_RRA:  begin r = {cin, a[7:1]};  co = a[0]; end
			MODE_SLA:            begin r = {a[6:0], 1'b0}; co = a[7]; end
			MODE_SRA:            begin r = {a[7], a[7:1]}; co = a[0]; end
			MODE_SLL:            begin r = {a[6:0], 1'b1}; co = a[7]; end
			MODE_SRL:            begin r = {1'b0, a[7:1]}; co = a[0]; end
			MODE_RES:            begin r = a & ~bmask; end
			MODE_SET:            begin r = a | bmask; end
			MODE_DAA: begin
				if (f[FL_H] || lo_gt9) begin
					corr = corr | DAA_LO_CORR;
				end
				if (cin || (a > 8'h99)) begin
					corr  = corr | DAA_HI_CORR;
					daa_c = 1'b1;
				end
				if (f[FL_N]) begin
					daa_h = f[FL_H] && (a[3:0] < 4'd6);
					r     = a - corr;
				end else begin
					daa_h = lo_gt9;
					r     = a + corr;
				end
			end
			MODE_CPL:            begin r = ~a; end
			MODE_NEG:            begin r = 8'd0 - a; end
			default:             begin r = a; end
		endcase

		case (req.mode)
			MODE_RLC, MODE_RRC, MODE_RL, MODE_RR,
			MODE_SLA, MODE_SRA, MODE_SLL, MODE_SRL: begin
				nf = {r[7], (r == 8'd0), r[5], 1'b0, r[3], ~^r, 1'b0, co};
			end
			MODE_BIT: begin
				nf = {(req.bit_index == 3'd7) && a[7], ~|(a & bmask), f[FL_5], 1'b1,
					f[FL_3], ~|(a & bmask), 1'b0, f[FL_C]};
			end
			MODE_RLCA, MODE_RRCA, MODE_RLA, MODE_RRA: begin
				nf = {f[FL_S], f[FL_Z], r[5], 1'b0, r[3], f[FL_P], 1'b0, co};
			end
			MODE_DAA: begin
				nf = {r[7], (r == 8'd0), r[5], daa_h, r[3], ~^r, f[FL_N], daa_c};
			end
			MODE_CPL: begin
				nf = {f[FL_S], f[FL_Z], r[5], 1'b1, r[3], f[FL_P], 1'b1, f[FL_C]};
			end
			MODE_NEG: begin
				nf = {r[7], (r == 8'd0), r[5], |a[3:0], r[3], (a == NEG_P_VAL), 1'b1,
					(a != 8'd0)};
			end
			MODE_SCF: begin
				nf = {f[FL_S], f[FL_Z], a[5], 1'b0, a[3], f[FL_P], 1'b0, 1'b1};
			end
			MODE_CCF: begin
				nf = {f[FL_S], f[FL_Z], a[5], cin, a[3], f[FL_P], 1'b0, ~cin};
			end
			default: begin
				nf = f;
			end
		endcase
	end

	assign rsp.result    = r;
	assign rsp.flags_out = nf;

endmodule

[hw/rtl/rotate_shift_bit_flag_alu_unit.sv]
// Path: a taken request is registered in req_s1, passes the combinational core,
// and its result is registered in rsp_s2, where done shows it.
// Throughput: one request per cycle; busy is always low.
// Results are strobed for one cycle on done; the receiver cannot stall.
// Reset clears the valid flags only; no result is strobed until a request arrives.
// ----------------------------------------------------------------------------
// rotate_shift_bit_flag_alu_unit
// 8-bit rotate/shift, bit test/set/reset and accumulator flag operations.
// ----------------------------------------------------------------------------
module rotate_shift_bit_flag_alu_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  rsfa_pkg::req_t req,
	output logic           done,
	output rsfa_pkg::rsp_t rsp
);
	import rsfa_pkg::*;

	req_t req_s1;
	logic valid_s1;
	rsp_t comb_rsp;
	rsp_t rsp_s2;
	logic valid_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
		if (valid_s1) begin
			rsp_s2 <= comb_rsp;
		end
	end

	rsfa_core u_core (
		.req (req_s1),
		.rsp (comb_rsp)
	);

	assign done = valid_s2;
	assign rsp  = rsp_s2;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("accepted request did not produce a result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> !done)
		else $error("result strobed without a request");

	a_scf: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && req_s1.mode == MODE_SCF) |=>
			(rsp.flags_out[FL_C] && !rsp.flags_out[FL_N] && !rsp.flags_out[FL_H]))
		else $error("SCF flags wrong");

	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && req_s1.mode == MODE_RES) |=>
			!rsp.result[$past(req_s1.bit_index)])
		else $error("RES left bit set");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rotate/shift/bit/flag ALU. A queue of requests
// (a directed set, then random ones) feeds a clocked driver with random idle
// cycles and drain pauses. A clocked monitor predicts each accepted request
// and checks every strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rsfa_pkg::*;

	localparam int RANDOM_OPS  = 1050;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		req_t        q;
		int unsigned hold;
		bit          drain;
	} queued_op_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	queued_op_t op_queue[$];
	rsp_t       expected_rsp[$];
	logic       taken = 1'b0;
	int         total_ops = 0;
	int         accepted_cnt = 0;
	int         err_count = 0;
	int         cycle_cnt = 0;

	rotate_shift_bit_flag_alu_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// S, Z, 5, 3 and even parity taken from a result byte
	function automatic logic [7:0] sz53p(logic [7:0] r);
		logic [7:0] f;
		f = '0;
		f[FL_S] = r[7];
		f[FL_5] = r[5];
		f[FL_3] = r[3];
		f[FL_Z] = (r == 8'h00);
		f[FL_P] = ~^r;
		return f;
	endfunction

	function automatic rsp_t alu_predict(req_t q);
		logic [7:0] a, f, r, nf, corr;
		logic       cin, co, h;
		rsp_t       p;
		a   = q.operand;
		f   = q.flags_in;
		r   = a;
		nf  = f;
		cin = f[FL_C];
		co  = 1'b0;
		case (q.mode)
			MODE_RLC, MODE_RLCA: begin
				r  = {a[6:0], a[7]};
				co = a[7];
			end
			MODE_RRC, MODE_RRCA: begin
				r  = {a[0], a[7:1]};
				co = a[0];
			end
			MODE_RL, MODE_RLA: begin
				r  = {a[6:0], cin};
				co = a[7];
			end
			MODE_RR, MODE_RRA: begin
				r  = {cin, a[7:1]};
				co = a[0];
			end
			MODE_SLA: begin
				r  = {a[6:0], 1'b0};
				co = a[7];
			end
			MODE_SRA: begin
				r  = {a[7], a[7:1]};
				co = a[0];
			end
			MODE_SLL: begin
				r  = {a[6:0], 1'b1};
				co = a[7];
			end
			MODE_SRL: begin
				r  = {1'b0, a[7:1]};
				co = a[0];
			end
			MODE_BIT: begin
				nf = '0;
				nf[FL_5] = f[FL_5];
				nf[FL_3] = f[FL_3];
				nf[FL_C] = f[FL_C];
				nf[FL_H] = 1'b1;
				nf[FL_Z] = ~a[q.bit_index];
				nf[FL_P] = ~a[q.bit_index];
				nf[FL_S] = (q.bit_index == 3'd7) && a[7];
			end
			MODE_RES: r[q.bit_index] = 1'b0;
			MODE_SET: r[q.bit_index] = 1'b1;
			MODE_DAA: begin
				corr = '0;
				co   = cin;
				if (f[FL_H] || a[3:0] > 4'd9)
					corr = corr | DAA_LO_CORR;
				if (cin || a > 8'h99) begin
					corr = corr | DAA_HI_CORR;
					co   = 1'b1;
				end
				if (f[FL_N]) begin
					h = f[FL_H] && (a[3:0] < 4'd6);
					r = a - corr;
				end else begin
					h = (a[3:0] > 4'd9);
					r = a + corr;
				end
				nf = sz53p(r);
				nf[FL_H] = h;
				nf[FL_N] = f[FL_N];
				nf[FL_C] = co;
			end
			MODE_CPL: begin
				r = ~a;
				nf[FL_5] = r[5];
				nf[FL_3] = r[3];
				nf[FL_H] = 1'b1;
				nf[FL_N] = 1'b1;
			end
			MODE_NEG: begin
				r  = 8'h00 - a;
				nf = '0;
				nf[FL_S] = r[7];
				nf[FL_5] = r[5];
				nf[FL_3] = r[3];
				nf[FL_Z] = (r == 8'h00);
				nf[FL_N] = 1'b1;
				nf[FL_C] = (a != 8'h00);
				nf[FL_P] = (a == NEG_P_VAL);
				nf[FL_H] = (a[3:0] != 4'h0);
			end
			MODE_SCF, MODE_CCF: begin
				nf[FL_5] = a[5];
				nf[FL_3] = a[3];
				nf[FL_N] = 1'b0;
				nf[FL_H] = (q.mode == MODE_CCF) ? cin : 1'b0;
				nf[FL_C] = (q.mode == MODE_CCF) ? ~cin : 1'b1;
			end
			default: ;
		endcase
		if (q.mode <= MODE_SRL) begin
			nf = sz53p(r);
			nf[FL_C] = co;
		end else if (q.mode >= MODE_RLCA && q.mode <= MODE_RRA) begin
			nf[FL_5] = r[5];
			nf[FL_3] = r[3];
			nf[FL_H] = 1'b0;
			nf[FL_N] = 1'b0;
			nf[FL_C] = co;
		end
		p.result    = r;
		p.flags_out = nf;
		return p;
	endfunction

	task automatic add_req(logic [4:0] mode, logic [7:0] a, logic [7:0] f, logic [2:0] idx);
		queued_op_t op;
		op.q.mode      = mode;
		op.q.operand   = a;
		op.q.flags_in  = f;
		op.q.bit_index = idx;
		op.hold        = 0;
		op.drain       = 1'b0;
		op_queue.push_back(op);
	endtask

	// driver: new request at the falling edge once the previous one was taken
	always @(negedge clk) begin : drv
		logic       nxt_start;
		req_t       nxt_req;
		queued_op_t nxt_op;
		nxt_start = 1'b0;
		nxt_req   = req;
		if (!arst_n) begin
			nxt_start = 1'b0;
		end else if (start && !taken) begin
			nxt_start = 1'b1;
		end else if (op_queue.size() != 0) begin
			if (op_queue[0].drain && expected_rsp.size() != 0) begin
				nxt_start = 1'b0;
			end else if (op_queue[0].hold != 0) begin
				op_queue[0].drain = 1'b0;
				op_queue[0].hold  = op_queue[0].hold - 1;
			end else begin
				nxt_op    = op_queue.pop_front();
				nxt_req   = nxt_op.q;
				nxt_start = 1'b1;
			end
		end
		start <= nxt_start;
		req   <= nxt_req;
	end

	// monitor: check strobed results, record accepted requests
	always @(posedge clk) begin : mon
		rsp_t e;
		if (!arst_n) begin
			taken <= 1'b0;
		end else begin
			if (done) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: unexpected result %h/%h", $time, rsp.result, rsp.flags_out);
					err_count++;
				end else begin
					e = expected_rsp.pop_front();
					if (rsp.result !== e.result) begin
						$display("%0t: result mismatch expected %h actual %h",
							$time, e.result, rsp.result);
						err_count++;
					end
					if (rsp.flags_out !== e.flags_out) begin
						$display("%0t: flags_out mismatch expected %h actual %h",
							$time, e.flags_out, rsp.flags_out);
						err_count++;
					end
				end
			end
			taken <= start && !busy;
			if (start && !busy) begin
				expected_rsp.push_back(alu_predict(req));
				accepted_cnt++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		queued_op_t op;
		int         i;
		// directed: extremes, every operation, flag corner cases
		add_req(MODE_RLC,  8'h80, 8'h00, 3'd0);
		add_req(MODE_RRC,  8'h01, 8'hFF, 3'd7);
		add_req(MODE_RL,   8'hFF, 8'h01, 3'd0);
		add_req(MODE_RR,   8'h00, 8'h01, 3'd0);
		add_req(MODE_SLA,  8'h80, 8'hFF, 3'd0);
		add_req(MODE_SRA,  8'h81, 8'h00, 3'd0);
		add_req(MODE_SLL,  8'h00, 8'h00, 3'd0);
		add_req(MODE_SRL,  8'h01, 8'hFF, 3'd0);
		add_req(MODE_BIT,  8'h80, 8'hFF, 3'd7);
		add_req(MODE_BIT,  8'h00, 8'h00, 3'd0);
		add_req(MODE_RES,  8'hFF, 8'hFF, 3'd7);
		add_req(MODE_SET,  8'h00, 8'h00, 3'd0);
		add_req(MODE_RLCA, 8'h80, 8'hC4, 3'd0);
		add_req(MODE_RRCA, 8'h01, 8'h00, 3'd0);
		add_req(MODE_RLA,  8'h7F, 8'h01, 3'd0);
		add_req(MODE_RRA,  8'hFE, 8'hFF, 3'd0);
		add_req(MODE_DAA,  8'h9A, 8'h00, 3'd0);
		add_req(MODE_DAA,  8'h15, 8'h12, 3'd0);
		add_req(MODE_DAA,  8'h00, 8'h01, 3'd0);
		add_req(MODE_CPL,  8'h55, 8'h00, 3'd0);
		add_req(MODE_NEG,  8'h80, 8'h00, 3'd0);
		add_req(MODE_NEG,  8'h00, 8'hFF, 3'd0);
		add_req(MODE_SCF,  8'h28, 8'hD7, 3'd0);
		add_req(MODE_CCF,  8'hFF, 8'h01, 3'd0);
		add_req(5'd31,     8'hA5, 8'h5A, 3'd5);

		for (i = 0; i < RANDOM_OPS; i++) begin
			if ($urandom_range(0, 99) < 6)
				op.q.mode = 5'($urandom_range(20, 31));
			else
				op.q.mode = 5'($urandom_range(0, 19));
			case ($urandom_range(0, 7))
				0: begin
					case ($urandom_range(0, 5))
						0: op.q.operand = 8'h00;
						1: op.q.operand = 8'hFF;
						2: op.q.operand = 8'h80;
						3: op.q.operand = 8'h7F;
						4: op.q.operand = 8'h99;
						default: op.q.operand = 8'h9A;
					endcase
				end
				default: op.q.operand = 8'($urandom);
			endcase
			op.q.flags_in  = 8'($urandom);
			op.q.bit_index = 3'($urandom_range(0, 7));
			op.hold = 0;
			if ((i < 400 || i >= 600) && $urandom_range(0, 99) < 24)
				op.hold = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 6) : 1;
			op.drain = (i % 150 == 0);
			op_queue.push_back(op);
		end
		total_ops = op_queue.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_cnt != total_ops || expected_rsp.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);

		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/rsfa_pkg.sv
hw/rtl/rsfa_core.sv
hw/rtl/rotate_shift_bit_flag_alu_unit.sv
tb/tb_top.sv
